### rtl/core/stkpf_pkg.sv
// Shared widths, defaults and register map of the spectral peak finder.
package stkpf_pkg;

   // Fixed field widths
   localparam int BIN_W      = 13;
   localparam int LEVEL_W    = 16;
   localparam int PW_W       = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 2;

   // Default sizes
   localparam int DEF_BIN_COUNT = 8192;
   localparam int DEF_MAX_PEAKS = 8;

   // Register reset values
   localparam logic [BIN_W-1:0]          RST_WINDOW_LOW  = 13'd1;
   localparam logic [BIN_W-1:0]          RST_WINDOW_HIGH = 13'd8190;
   localparam logic [PW_W-1:0]           RST_PEAKS       = 4'd8;
   localparam logic signed [LEVEL_W-1:0] RST_PILOT_MIN   = 16'sh8000;

   // Configuration register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_LOW  = 3'd0,
      CSR_WINDOW_HIGH = 3'd1,
      CSR_PEAKS       = 3'd2,
      CSR_PILOT_EN    = 3'd3,
      CSR_PILOT_LOW   = 3'd4,
      CSR_PILOT_HIGH  = 3'd5,
      CSR_PILOT_MIN   = 3'd6
   } csr_index_type;

endpackage

### rtl/core/spectral_top_k_peak_finder_top.sv
// Top level of the streaming top-k local-maximum spectral peak finder.
// Usage:
//  - req_* carries one spectrum bin level per transaction; req_tlast marks the
//    last bin of a frame. One bin per cycle while req_tready is high, no gaps needed.
//  - A bin that is strictly above both neighbours and strictly inside the
//    window (edges clamped to 1 .. BIN_COUNT-2) goes into a descending list
//    of up to min(peaks_wanted, MAX_PEAKS) entries; equal levels keep the
//    earlier bin first.
//  - On the last bin the list is copied to an output shift buffer and the
//    frame state clears. rsp_* then gives one transaction per kept peak,
//    strongest first, starting the cycle after the last bin; rsp_tlast marks
//    the final one. A frame with no peak gives one transaction with
//    peak_found low and bin and level zero.
//  - Throughput is one bin per cycle. req_tready drops only for a last bin
//    that arrives while the previous frame's results are still queued, since
//    the single output buffer holds one frame's results.
//  - A stall on rsp_* holds the current result; bins short of a frame's last bin keep flowing.
//  - csr_* writes one register per transaction, always ready; write only while idle.
//  - Reset (synchronous, active high) restores register defaults, empties
//    the list and drops any queued results.
module spectral_top_k_peak_finder_top
   import stkpf_pkg::*;
#(
   parameter int BIN_COUNT = DEF_BIN_COUNT,
   parameter int MAX_PEAKS = DEF_MAX_PEAKS
) (
   input  logic                  clock,
   input  logic                  reset,
   // bin stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [15:0] bin_level
   input  logic                  req_tlast,  // frame_end
   // peak stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [12:0] peak_bin, [28:13] peak_level, 0 pad
   output logic [RSP_USER_W-1:0] rsp_tuser,  // [0] pilot_flag, [1] peak_found
   output logic                  rsp_tlast,  // last_peak
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int POS_W = $clog2(BIN_COUNT + 1);
   localparam int CMP_W = (POS_W > BIN_W) ? POS_W : BIN_W;
   localparam int CNT_W = $clog2(MAX_PEAKS + 1);
   localparam int LIM_W = (CNT_W > PW_W) ? CNT_W : PW_W;

   localparam logic [CMP_W-1:0] EDGE_MIN  = CMP_W'(1);
   localparam logic [CMP_W-1:0] EDGE_MAX  = CMP_W'(BIN_COUNT - 2);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(BIN_COUNT);
   localparam logic [LIM_W-1:0] PEAK_MAX  = LIM_W'(MAX_PEAKS);

   // Configuration registers
   logic [BIN_W-1:0]          window_low_ff, window_high_ff;
   logic [PW_W-1:0]           peaks_wanted_ff;
   logic                      pilot_enable_ff;
   logic [BIN_W-1:0]          pilot_low_ff, pilot_high_ff;
   logic signed [LEVEL_W-1:0] pilot_min_ff;

   // Frame state
   logic [POS_W-1:0]          bin_position_ff, bin_position_in;
   logic signed [LEVEL_W-1:0] previous_level_ff, older_level_ff;
   logic [BIN_W-1:0]          kept_bin_ff   [MAX_PEAKS];
   logic signed [LEVEL_W-1:0] kept_level_ff [MAX_PEAKS];
   logic [BIN_W-1:0]          kept_bin_in   [MAX_PEAKS];
   logic signed [LEVEL_W-1:0] kept_level_in [MAX_PEAKS];
   logic [CNT_W-1:0]          kept_count_ff, kept_count_in;

   // Output shift buffer
   logic [BIN_W-1:0]          emit_bin_ff   [MAX_PEAKS];
   logic signed [LEVEL_W-1:0] emit_level_ff [MAX_PEAKS];
   logic [MAX_PEAKS-1:0]      emit_pilot_ff;
   logic                      emit_found_ff;
   logic [CNT_W-1:0]          emit_left_ff;

   // Combinational helpers
   logic signed [LEVEL_W-1:0] cur_level;
   logic                      req_fire, rsp_fire, frame_fire;
   logic [CMP_W-1:0]          edge_lo, edge_hi, cand_bin;
   logic                      is_candidate, blocked, do_insert;
   logic [LIM_W-1:0]          keep_cap, count_ext, top, count_next_ext, emit_n;
   logic [MAX_PEAKS-1:0]      ge_vec;
   logic                      buffer_busy;

   assign cur_level  = signed'(req_tdata[LEVEL_W-1:0]);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign frame_fire = req_fire && req_tlast;
   assign csr_ready  = 1'b1;

   // Buffer stays occupied unless its final result leaves this cycle
   assign buffer_busy = (emit_left_ff != '0) &&
                        !(rsp_tready && (emit_left_ff == CNT_W'(1)));
   assign req_tready  = !(buffer_busy && req_tlast);

   // Configuration write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         window_low_ff   <= RST_WINDOW_LOW;
         window_high_ff  <= RST_WINDOW_HIGH;
         peaks_wanted_ff <= RST_PEAKS;
         pilot_enable_ff <= 1'b0;
         pilot_low_ff    <= '0;
         pilot_high_ff   <= '0;
         pilot_min_ff    <= RST_PILOT_MIN;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WINDOW_LOW:  window_low_ff   <= csr_data[BIN_W-1:0];
            CSR_WINDOW_HIGH: window_high_ff  <= csr_data[BIN_W-1:0];
            CSR_PEAKS:       peaks_wanted_ff <= csr_data[PW_W-1:0];
            CSR_PILOT_EN:    pilot_enable_ff <= csr_data[0];
            CSR_PILOT_LOW:   pilot_low_ff    <= csr_data[BIN_W-1:0];
            CSR_PILOT_HIGH:  pilot_high_ff   <= csr_data[BIN_W-1:0];
            CSR_PILOT_MIN:   pilot_min_ff    <= signed'(csr_data[LEVEL_W-1:0]);
            default: ;
         endcase
      end
   end

   // Window edges, clamped
   always_comb begin
      edge_lo = CMP_W'(window_low_ff);
      if (edge_lo < EDGE_MIN) edge_lo = EDGE_MIN;
      if (edge_lo > EDGE_MAX) edge_lo = EDGE_MAX;
      edge_hi = CMP_W'(window_high_ff);
      if (edge_hi < EDGE_MIN) edge_hi = EDGE_MIN;
      if (edge_hi > EDGE_MAX) edge_hi = EDGE_MAX;
   end

   // Local maximum test on the previous bin
   always_comb begin
      cand_bin     = CMP_W'(bin_position_ff - POS_W'(1));
      is_candidate = (bin_position_ff >= POS_W'(2)) && (edge_lo < edge_hi) &&
                     (cand_bin > edge_lo) && (cand_bin < edge_hi) &&
                     (previous_level_ff > older_level_ff) &&
                     (previous_level_ff > cur_level);
   end

   // Sorted insert: parallel compares, then each slot keeps, takes new or shifts
   always_comb begin
      keep_cap  = (LIM_W'(peaks_wanted_ff) > PEAK_MAX) ? PEAK_MAX
                                                       : LIM_W'(peaks_wanted_ff);
      count_ext = LIM_W'(kept_count_ff);
      for (int i = 0; i < MAX_PEAKS; i++) begin
         ge_vec[i] = (CNT_W'(i) < kept_count_ff) && (kept_level_ff[i] >= previous_level_ff);
      end
      // full below the insert point when the slot at keep_cap-1 holds an equal or stronger peak
      blocked = 1'b0;
      for (int i = 0; i < MAX_PEAKS; i++) begin
         if (LIM_W'(i) + LIM_W'(1) == keep_cap) blocked = ge_vec[i];
      end
      do_insert = is_candidate && (keep_cap != '0) && !blocked;
      top = (count_ext > keep_cap - LIM_W'(1)) ? keep_cap - LIM_W'(1) : count_ext;

      for (int i = 0; i < MAX_PEAKS; i++) begin
         kept_bin_in[i]   = kept_bin_ff[i];
         kept_level_in[i] = kept_level_ff[i];
         if (do_insert && !ge_vec[i]) begin
            if (i == 0 || ge_vec[(i == 0) ? 0 : i - 1]) begin
               kept_bin_in[i]   = BIN_W'(cand_bin);
               kept_level_in[i] = previous_level_ff;
            end else begin
               kept_bin_in[i]   = kept_bin_ff[(i == 0) ? 0 : i - 1];
               kept_level_in[i] = kept_level_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end
      count_next_ext = do_insert ? top + LIM_W'(1) : count_ext;
      emit_n         = (count_next_ext > keep_cap) ? keep_cap : count_next_ext;
      kept_count_in  = frame_fire ? '0 : CNT_W'(count_next_ext);
   end

   // Bin counter stops at BIN_COUNT, clears on the frame's last bin
   always_comb begin
      if (req_tlast)                       bin_position_in = '0;
      else if (bin_position_ff < POS_LIMIT) bin_position_in = bin_position_ff + POS_W'(1);
      else                                  bin_position_in = bin_position_ff;
   end

   // Frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_position_ff   <= '0;
         previous_level_ff <= '0;
         older_level_ff    <= '0;
         kept_count_ff     <= '0;
      end else if (req_fire) begin
         bin_position_ff   <= bin_position_in;
         older_level_ff    <= previous_level_ff;
         previous_level_ff <= cur_level;
         kept_count_ff     <= kept_count_in;
      end
   end

   // Peak list payload, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < MAX_PEAKS; i++) begin
            kept_bin_ff[i]   <= kept_bin_in[i];
            kept_level_ff[i] <= kept_level_in[i];
         end
      end
   end

   // Output buffer count
   always_ff @(posedge clock) begin
      if (reset) begin
         emit_left_ff <= '0;
      end else if (frame_fire) begin
         emit_left_ff <= (emit_n == '0) ? CNT_W'(1) : CNT_W'(emit_n);
      end else if (rsp_fire) begin
         emit_left_ff <= emit_left_ff - CNT_W'(1);
      end
   end

   // Output buffer payload: load a frame's list, shift one entry per result
   always_ff @(posedge clock) begin
      if (frame_fire) begin
         emit_found_ff <= (emit_n != '0);
         for (int i = 0; i < MAX_PEAKS; i++) begin
            // empty frame reports bin and level zero in the head slot
            if (i == 0 && emit_n == '0) begin
               emit_bin_ff[i]   <= '0;
               emit_level_ff[i] <= '0;
            end else begin
               emit_bin_ff[i]   <= kept_bin_in[i];
               emit_level_ff[i] <= kept_level_in[i];
            end
            emit_pilot_ff[i] <= pilot_enable_ff && (emit_n != '0) &&
                                (kept_bin_in[i] >= pilot_low_ff) &&
                                (kept_bin_in[i] <= pilot_high_ff) &&
                                (kept_level_in[i] >= pilot_min_ff);
         end
      end else if (rsp_fire) begin
         for (int i = 0; i + 1 < MAX_PEAKS; i++) begin
            emit_bin_ff[i]   <= emit_bin_ff[i + 1];
            emit_level_ff[i] <= emit_level_ff[i + 1];
            emit_pilot_ff[i] <= emit_pilot_ff[i + 1];
         end
      end
   end

   // Result channel
   assign rsp_tvalid = (emit_left_ff != '0);
   assign rsp_tdata  = {{(RSP_DATA_W - LEVEL_W - BIN_W){1'b0}},
                        emit_level_ff[0], emit_bin_ff[0]};
   assign rsp_tuser  = {emit_found_ff, emit_pilot_ff[0]};
   assign rsp_tlast  = (emit_left_ff == CNT_W'(1));

   // Assertions

   // A frame's results are never overwritten while still queued
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      frame_fire |-> (emit_left_ff == '0) ||
                     (rsp_tready && (emit_left_ff == CNT_W'(1))))
      else $error("frame list loaded over pending results");

   // The list never holds more entries than its storage
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      kept_count_ff <= CNT_W'(MAX_PEAKS))
      else $error("kept count exceeds list depth");

   // An empty-frame result is always alone and last
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !emit_found_ff) |-> rsp_tlast)
      else $error("empty-frame result not marked last");

   // The list stays sorted strongest first
   for (genvar g = 0; g + 1 < MAX_PEAKS; g++) begin : g_order
      a_sorted: assert property (@(posedge clock) disable iff (reset)
         (CNT_W'(g + 1) < kept_count_ff) |-> (kept_level_ff[g] >= kept_level_ff[g + 1]))
         else $error("peak list out of order");
   end

endmodule

### tb/tb_spectral_top_k_peak_finder_top.sv
// Self-checking testbench for the spectral top-k peak finder.
`timescale 1ns / 100ps

module tb_spectral_top_k_peak_finder_top;
   import stkpf_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 6;

   // One peak transaction as it leaves the block
   typedef struct packed {
      logic [BIN_W-1:0]   bin;
      logic [LEVEL_W-1:0] level;
      logic               pilot;
      logic               found;
      logic               last;
   } peak_rec_type;

   // Register set as last written
   typedef struct {
      logic [BIN_W-1:0]          win_lo;
      logic [BIN_W-1:0]          win_hi;
      logic [PW_W-1:0]           peaks;
      logic                      pilot_en;
      logic [BIN_W-1:0]          pilot_lo;
      logic [BIN_W-1:0]          pilot_hi;
      logic signed [LEVEL_W-1:0] pilot_min;
   } csr_set_type;

   typedef enum int {LEVELS_WIDE, LEVELS_FLAT, LEVELS_ZIGZAG} level_shape_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [15:0] bin_level
   logic                  req_tlast = 1'b0; // frame_end
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [12:0] peak_bin, [28:13] peak_level
   logic [RSP_USER_W-1:0] rsp_tuser;        // [0] pilot_flag, [1] peak_found
   logic                  rsp_tlast;        // last_peak
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   spectral_top_k_peak_finder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Predictor state: frame tracking plus the kept peak list
   csr_set_type               cfg;
   int unsigned               bin_pos = 0;
   logic signed [LEVEL_W-1:0] prev_lvl = '0;
   logic signed [LEVEL_W-1:0] older_lvl = '0;
   logic [BIN_W-1:0]          kept_bin [DEF_MAX_PEAKS];
   logic signed [LEVEL_W-1:0] kept_lvl [DEF_MAX_PEAKS];
   int unsigned               kept_n = 0;
   peak_rec_type              pending_peaks[$];

   // Run bookkeeping
   int sender_idle_pct = 29;
   int sink_idle_pct   = 88;
   int cycle_count     = 0;
   int mismatch_count  = 0;
   int peaks_checked   = 0;
   int frames_sent     = 0;
   int bins_sent       = 0;
   int settings_used   = 0;
   peak_rec_type got_peak;
   peak_rec_type want_peak;

   initial begin
      cfg.win_lo    = RST_WINDOW_LOW;
      cfg.win_hi    = RST_WINDOW_HIGH;
      cfg.peaks     = RST_PEAKS;
      cfg.pilot_en  = 1'b0;
      cfg.pilot_lo  = '0;
      cfg.pilot_hi  = '0;
      cfg.pilot_min = RST_PILOT_MIN;
   end

   function automatic int unsigned edge_clamp(input logic [BIN_W-1:0] e);
      if (e < 1) return 1;
      if (e > DEF_BIN_COUNT - 2) return DEF_BIN_COUNT - 2;
      return 32'(e);
   endfunction

   // Advance the predictor by one accepted bin; queue the peaks a frame end releases
   task automatic predict_bin(input logic signed [LEVEL_W-1:0] lvl, input logic eof);
      int unsigned pos, cand, lo, hi, cap, n, p, top;
      int i;
      peak_rec_type rec;
      pos = bin_pos;
      cap = (cfg.peaks > DEF_MAX_PEAKS) ? DEF_MAX_PEAKS : 32'(cfg.peaks);
      if (pos >= 2) begin
         cand = pos - 1;
         lo = edge_clamp(cfg.win_lo);
         hi = edge_clamp(cfg.win_hi);
         if (lo < hi && cand > lo && cand < hi && cap != 0 &&
             prev_lvl > older_lvl && prev_lvl > lvl) begin
            // equal levels go behind the ones already kept
            p = 0;
            while (p < kept_n && kept_lvl[p] >= prev_lvl) p++;
            if (p < cap) begin
               top = (kept_n > cap - 1) ? cap - 1 : kept_n;
               for (i = top; i > p; i--) begin
                  kept_bin[i] = kept_bin[i-1];
                  kept_lvl[i] = kept_lvl[i-1];
               end
               kept_bin[p] = cand[BIN_W-1:0];
               kept_lvl[p] = prev_lvl;
               kept_n = top + 1;
            end
         end
      end
      older_lvl = prev_lvl;
      prev_lvl  = lvl;

      if (!eof) begin
         if (pos < DEF_BIN_COUNT) bin_pos = pos + 1;
      end else begin
         n = (kept_n > cap) ? cap : kept_n;
         if (n == 0) begin
            rec = '0;
            rec.last = 1'b1;
            pending_peaks = {pending_peaks, rec};
         end
         for (i = 0; i < n; i++) begin
            rec.bin   = kept_bin[i];
            rec.level = kept_lvl[i];
            rec.pilot = cfg.pilot_en && kept_bin[i] >= cfg.pilot_lo &&
                        kept_bin[i] <= cfg.pilot_hi && kept_lvl[i] >= cfg.pilot_min;
            rec.found = 1'b1;
            rec.last  = (i == n - 1);
            pending_peaks = {pending_peaks, rec};
         end
         bin_pos = 0;
         kept_n  = 0;
      end
   endtask

   // Send one bin; entered and left at a falling edge, tvalid stays up for the next bin
   task automatic send_bin(input logic signed [LEVEL_W-1:0] lvl, input logic eof);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= lvl;
      req_tlast  <= eof;
      do @(posedge clock); while (!req_tready);
      predict_bin(lvl, eof);
      bins_sent++;
      if (eof) frames_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input int len, input level_shape_type shape);
      logic signed [LEVEL_W-1:0] lvl;
      int i;
      for (i = 0; i < len; i++) begin
         case (shape)
            LEVELS_WIDE: lvl = LEVEL_W'($urandom);
            LEVELS_FLAT: lvl = LEVEL_W'($urandom_range(0, 4)) - LEVEL_W'(2);
            default: begin
               // alternate highs and lows so peaks crowd the list
               lvl = LEVEL_W'($urandom_range(0, 40) * 75);
               if (i % 2 == 0) lvl = -lvl;
            end
         endcase
         send_bin(lvl, i == len - 1);
      end
   endtask

   // Stop sending, let every queued peak come out, then let the block settle
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_peaks.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_WINDOW_LOW:  cfg.win_lo    = val[BIN_W-1:0];
         CSR_WINDOW_HIGH: cfg.win_hi    = val[BIN_W-1:0];
         CSR_PEAKS:       cfg.peaks     = val[PW_W-1:0];
         CSR_PILOT_EN:    cfg.pilot_en  = val[0];
         CSR_PILOT_LOW:   cfg.pilot_lo  = val[BIN_W-1:0];
         CSR_PILOT_HIGH:  cfg.pilot_hi  = val[BIN_W-1:0];
         CSR_PILOT_MIN:   cfg.pilot_min = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Full register set, written only once the block has gone idle
   task automatic apply_config(input csr_set_type s);
      drain_results();
      csr_write(CSR_WINDOW_LOW,  {3'b0, s.win_lo});
      csr_write(CSR_WINDOW_HIGH, {3'b0, s.win_hi});
      csr_write(CSR_PEAKS,       {12'b0, s.peaks});
      csr_write(CSR_PILOT_EN,    {15'b0, s.pilot_en});
      csr_write(CSR_PILOT_LOW,   {3'b0, s.pilot_lo});
      csr_write(CSR_PILOT_HIGH,  {3'b0, s.pilot_hi});
      csr_write(CSR_PILOT_MIN,   s.pilot_min);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic csr_set_type default_setting();
      csr_set_type s;
      s.win_lo    = RST_WINDOW_LOW;
      s.win_hi    = RST_WINDOW_HIGH;
      s.peaks     = RST_PEAKS;
      s.pilot_en  = 1'b0;
      s.pilot_lo  = '0;
      s.pilot_hi  = '0;
      s.pilot_min = RST_PILOT_MIN;
      return s;
   endfunction

   // Mostly windows that land inside short frames, with the extremes mixed in
   function automatic csr_set_type random_setting();
      csr_set_type s;
      case ($urandom_range(0, 9))
         0:       s.win_lo = 13'd0;
         1:       s.win_lo = 13'd8191;
         2:       s.win_lo = 13'd8190;
         default: s.win_lo = BIN_W'($urandom_range(0, 30));
      endcase
      case ($urandom_range(0, 9))
         0:       s.win_hi = 13'd8191;
         1:       s.win_hi = 13'd8190;
         2:       s.win_hi = 13'd0;
         default: s.win_hi = BIN_W'($urandom_range(0, 45));
      endcase
      s.peaks    = PW_W'($urandom_range(0, 15));
      s.pilot_en = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
         0:       s.pilot_lo = 13'd0;
         1:       s.pilot_lo = 13'd8191;
         default: s.pilot_lo = BIN_W'($urandom_range(0, 40));
      endcase
      s.pilot_hi = ($urandom_range(0, 7) == 0) ? 13'd8191 : 13'($urandom_range(0, 45));
      case ($urandom_range(0, 7))
         0:       s.pilot_min = 16'sh8000;
         1:       s.pilot_min = 16'sh7FFF;
         2:       s.pilot_min = LEVEL_W'($urandom);
         default: s.pilot_min = LEVEL_W'($urandom_range(0, 4000)) - LEVEL_W'(2000);
      endcase
      return s;
   endfunction

   // Level extremes and alternating bit patterns under the reset settings
   task automatic test_extreme_levels();
      logic signed [LEVEL_W-1:0] lv [9] = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh5555,
                                           16'shAAAA, 16'sh0000, 16'sh7FFF, 16'sh7FFF,
                                           16'sh0001};
      int i;
      for (i = 0; i < 9; i++) send_bin(lv[i], i == 8);
   endtask

   // One- and two-bin frames have no candidate and give the empty result
   task automatic test_short_frames();
      send_bin(16'sh7FFF, 1'b1);
      send_bin(16'sh0100, 1'b0);
      send_bin(16'sh8000, 1'b1);
   endtask

   // Equal peaks: the earlier bin stays ahead of the later one in the list
   task automatic test_tie_order();
      csr_set_type s;
      int i;
      s = default_setting();
      s.peaks     = 4'd2;
      s.pilot_en  = 1'b1;
      s.pilot_lo  = 13'd3;
      s.pilot_hi  = 13'd3;
      s.pilot_min = 16'sd5;
      apply_config(s);
      for (i = 0; i < 7; i++) send_bin((i % 2) ? 16'sd5 : 16'sd0, i == 6);
   endtask

   // Nothing kept when zero peaks are wanted; the clear maximum here sits at bin 1, on the window edge
   task automatic test_zero_peaks();
      csr_set_type s;
      s = default_setting();
      s.peaks = 4'd0;
      apply_config(s);
      send_bin(16'sd0, 1'b0);
      send_bin(16'sd1, 1'b0);
      send_bin(16'sd0, 1'b0);
      send_bin(16'sd0, 1'b1);
   endtask

   task automatic test_random_frames(input int src_pct, input int sink_pct, input int bin_goal);
      int sent, len;
      sender_idle_pct = src_pct;
      sink_idle_pct   = sink_pct;
      sent = 0;
      while (sent < bin_goal) begin
         if ($urandom_range(0, 2) == 0) apply_config(random_setting());
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
         send_frame(len, level_shape_type'($urandom_range(0, 2)));
         sent += len;
      end
   endtask

   // Receiver stalls at random, one decision per cycle
   always @(negedge clock) rsp_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

   // Compare each peak transaction with the oldest one predicted
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_peak.bin   = rsp_tdata[BIN_W-1:0];
         got_peak.level = rsp_tdata[BIN_W+LEVEL_W-1:BIN_W];
         got_peak.pilot = rsp_tuser[0];
         got_peak.found = rsp_tuser[1];
         got_peak.last  = rsp_tlast;
         if (pending_peaks.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected peak: bin %0d level %0d", got_peak.bin,
                        $signed(got_peak.level));
            mismatch_count++;
         end else begin
            want_peak = pending_peaks.pop_front();
            peaks_checked++;
            if (got_peak !== want_peak || rsp_tdata[RSP_DATA_W-1:BIN_W+LEVEL_W] !== '0) begin
               if (mismatch_count < 10)
                  $display("mismatch: exp %0d %0d %b %b %b got %0d %0d %b %b %b pad %h",
                           want_peak.bin, $signed(want_peak.level), want_peak.pilot,
                           want_peak.found, want_peak.last, got_peak.bin,
                           $signed(got_peak.level), got_peak.pilot, got_peak.found,
                           got_peak.last, rsp_tdata[RSP_DATA_W-1:BIN_W+LEVEL_W]);
               mismatch_count++;
            end
         end
      end
   end

   // Run time guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d peaks outstanding", cycle_count,
                  pending_peaks.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_extreme_levels();
      test_short_frames();
      test_tie_order();
      test_zero_peaks();
      test_random_frames(29, 88, 150);
      test_random_frames(88, 29, 150);
      test_random_frames(0, 0, 150);
      drain_results();

      $display("run covered %0d frames, %0d bins, %0d register settings under stalls",
               frames_sent, bins_sent, settings_used);
      $display("checked %0d peak transactions, %0d mismatches", peaks_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
